[hw/rtl/xfse_pkg.sv]
// Shared types and constants for the XOR float stream encoder.
// No dependencies; every other file of the block imports this package.
package xfse_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned COUNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // kind codes on the result channel
  localparam logic KIND_RAW  = 1'b0;
  localparam logic KIND_CODE = 1'b1;

  // control bit patterns and their lengths
  localparam logic [1:0]       CTRL_REUSE = 2'b10;
  localparam logic [1:0]       CTRL_NEW   = 2'b11;
  localparam logic [LEN_W-1:0] LEN_ZERO   = 7'd1;
  localparam logic [LEN_W-1:0] LEN_REUSE  = 7'd2;
  localparam logic [LEN_W-1:0] LEN_NEW    = 7'd12;
  localparam logic [LEN_W-1:0] LEN_RAW    = 7'd64;

  // one result beat
  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              last;
  } chunk_t;

  // everything one sample produces: one or two beats
  typedef struct packed {
    logic   two;
    chunk_t first;
    chunk_t second;
  } enc_pair_t;

  // handshake between the input register and the encoder
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] value_bits;
    logic              new_series;
  } sample_t;

endpackage

[hw/rtl/xfse_stream_if.sv]
// Valid/ready channel interfaces for samples in and chunks out.
// Depends on xfse_pkg for the field widths.
interface xfse_sample_if;
  import xfse_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value_bits;
  logic              new_series;

  modport source (output valid, output value_bits, output new_series, input ready);
  modport sink   (input valid, input value_bits, input new_series, output ready);
endinterface

interface xfse_chunk_if;
  import xfse_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] chunk_bits;
  logic [LEN_W-1:0]  chunk_len;
  logic              last;

  modport source (output valid, output kind, output chunk_bits, output chunk_len,
                  output last, input ready);
  modport sink   (input valid, input kind, input chunk_bits, input chunk_len,
                  input last, output ready);
endinterface

[hw/rtl/xfse_in_stage.sv]
// Input register for the sample channel.
// Depends on xfse_pkg and xfse_sample_if.
module xfse_in_stage
  import xfse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  xfse_sample_if.sink  samples,
  input  logic         load,
  output sample_t      held
);

  logic              valid;
  logic [WORD_W-1:0] value_bits;
  logic              new_series;

  // take a beat when empty or when the held sample moves on
  assign samples.ready = !valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (samples.ready) begin
      valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      value_bits <= samples.value_bits;
      new_series <= samples.new_series;
    end
  end

  assign held = '{valid: valid, value_bits: value_bits, new_series: new_series};

endmodule

[hw/rtl/xfse_encode.sv]
// Encoder core: XOR with the previous value, zero counts, header and payload.
// Holds the series state. Depends on xfse_pkg.
module xfse_encode
  import xfse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sample_t   held,
  input  logic      load,
  output enc_pair_t pair
);

  logic               started;
  logic [WORD_W-1:0]  prev_value;
  logic [COUNT_W-1:0] prev_lead;
  logic [COUNT_W-1:0] prev_tail;

  logic [WORD_W-1:0]  diff;
  logic [COUNT_W-1:0] lead;
  logic [COUNT_W-1:0] tail;
  logic               raw;
  logic               reuse;
  logic [LEN_W-1:0]   payload_len;

  assign raw  = held.new_series || !started;
  assign diff = prev_value ^ held.value_bits;

  // leading zero count, saturated
  always_comb begin
    lead = COUNT_MAX;
    for (int i = 30; i >= 0; i--) begin
      if (diff[WORD_W-1-i]) begin
        lead = COUNT_W'(i);
      end
    end
  end

  // trailing zero count, saturated
  always_comb begin
    tail = COUNT_MAX;
    for (int i = 30; i >= 0; i--) begin
      if (diff[i]) begin
        tail = COUNT_W'(i);
      end
    end
  end

  assign reuse       = (lead == prev_lead) && (tail == prev_tail);
  assign payload_len = LEN_RAW - {2'b00, lead} - {2'b00, tail};

  // build the beats for this sample
  always_comb begin
    pair.second = '{kind: KIND_CODE, bits: diff >> tail, len: payload_len, last: 1'b1};
    if (raw) begin
      pair.two   = 1'b0;
      pair.first = '{kind: KIND_RAW, bits: held.value_bits, len: LEN_RAW, last: 1'b1};
    end else if (diff == '0) begin
      pair.two   = 1'b0;
      pair.first = '{kind: KIND_CODE, bits: '0, len: LEN_ZERO, last: 1'b1};
    end else if (reuse) begin
      pair.two   = 1'b1;
      pair.first = '{kind: KIND_CODE, bits: {62'd0, CTRL_REUSE}, len: LEN_REUSE,
                     last: 1'b0};
    end else begin
      pair.two   = 1'b1;
      pair.first = '{kind: KIND_CODE, bits: {52'd0, CTRL_NEW, lead, tail},
                     len: LEN_NEW, last: 1'b0};
    end
  end

  // advance the series state as each sample is encoded; a repeated value leaves it unchanged
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      prev_value <= '0;
      prev_lead  <= '0;
      prev_tail  <= '0;
    end else if (load) begin
      if (raw) begin
        started    <= 1'b1;
        prev_value <= held.value_bits;
        prev_lead  <= '0;
        prev_tail  <= '0;
      end else if (diff != '0) begin
        prev_value <= held.value_bits;
        prev_lead  <= lead;
        prev_tail  <= tail;
      end
    end
  end

endmodule

[hw/rtl/xfse_out_queue.sv]
// Two-slot result register feeding the chunk channel one beat per cycle while the receiver is ready.
// Depends on xfse_pkg and xfse_chunk_if.
module xfse_out_queue
  import xfse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         held_valid,
  input  enc_pair_t    pair,
  output logic         load,
  xfse_chunk_if.source chunks
);

  logic [1:0] fill;
  chunk_t     slot0;
  chunk_t     slot1;
  logic       take;
  logic       space;

  assign take  = (fill != 2'd0) && chunks.ready;
  assign space = (fill == 2'd0) || ((fill == 2'd1) && take);
  assign load  = held_valid && space;

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (load) begin
      fill <= pair.two ? 2'd2 : 2'd1;
    end else if (take) begin
      fill <= fill - 2'd1;
    end
  end

  // fill both slots on load, shift down on a taken beat
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= pair.first;
      slot1 <= pair.second;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

  assign chunks.valid      = (fill != 2'd0);
  assign chunks.kind       = slot0.kind;
  assign chunks.chunk_bits = slot0.bits;
  assign chunks.chunk_len  = slot0.len;
  assign chunks.last       = slot0.last;

endmodule

[hw/rtl/xor_float_stream_encoder.sv]
// XOR float stream encoder, top level.
// Depends on xfse_pkg, the stream interfaces, xfse_in_stage, xfse_encode, xfse_out_queue.
//
// Usage:
//   samples: one 64-bit double bit pattern per beat, with new_series set on
//            the first value of a series (the very first value after reset is
//            always taken as a series start).
//   chunks:  result beats. A series start gives one raw beat (kind 0, 64 bits).
//            A repeated value gives one beat holding the single bit 0. A changed
//            value gives a header beat (last 0) and then a payload beat (last 1).
//            Bits are right-aligned; the first bit sent is bit chunk_len-1.
// A sample accepted into the input register is encoded and then loaded into the
//   two-slot result register, from which its first beat goes out on chunks.
// Throughput: the chunk channel moves one beat per cycle while the receiver is
//   ready; the two-slot result register takes the next sample as the last
//   pending beat of the previous one is taken.
// Reset (rst, synchronous, active high) empties both registers and clears the
//   series state. When the receiver stalls, the pending beats hold, one
//   further sample is held in the input register, and then samples.ready drops.
module xor_float_stream_encoder
  import xfse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  xfse_sample_if.sink  samples,
  xfse_chunk_if.source chunks
);

  sample_t   held;
  enc_pair_t pair;
  logic      load;

  xfse_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .load    (load),
    .held    (held)
  );

  xfse_encode u_encode (
    .clk  (clk),
    .rst  (rst),
    .held (held),
    .load (load),
    .pair (pair)
  );

  xfse_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held.valid),
    .pair       (pair),
    .load       (load),
    .chunks     (chunks)
  );

endmodule
